@@ rtl/core/romf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// romf_pkg: shared types and constants of the range outlier mean filter
// Field widths, register indexes, limits, item classes and back-end states.
// ----------------------------------------------------------------------------
package romf_pkg;

   localparam int ORIENT_W   = 8;
   localparam int DIST_W     = 16;
   localparam int TYPE_W     = 8;
   localparam int ERR_W      = 32;
   localparam int WIN_W      = 8;
   localparam int GAIN_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int MEAN_INT_W = 10;
   localparam int MEAN_W     = MEAN_INT_W + FRAC_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ORIENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_GAIN   = 2'd2;

   localparam logic [ORIENT_W-1:0] ORIENT_RESET = 8'd25;
   localparam logic [WIN_W-1:0]    WINDOW_RESET = 8'd0;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd6554;

   localparam logic [DIST_W-1:0] DIST_MIN = 16'd5;
   localparam logic [DIST_W-1:0] DIST_MAX = 16'd600;
   localparam int DEV_SCALE = 200;
   localparam int GAIN_DIV  = 10;

   // gain divider: quotient bits 17 down to 0, saturated at 1.0 (Q1.16)
   localparam int DIV_STEPS = 18;
   localparam int CNT_W     = 5;
   localparam logic [GAIN_W:0] Q16_ONE = 17'h10000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [1:0] {
      CLS_SKIP,
      CLS_RANGE,
      CLS_PASS,
      CLS_FILTER
   } cls_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_MUL,
      BK_CMP,
      BK_DIV,
      BK_GAIN,
      BK_UPD,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      logic [ORIENT_W-1:0] orient;
      logic [WIN_W-1:0]    window;
      logic [GAIN_W-1:0]   gain;
   } cfg_type;

   typedef struct packed {
      cls_type             cls;
      logic [DIST_W-1:0]   range_cm;
      logic [TYPE_W-1:0]   stype;
   } entry_type;

   typedef struct packed {
      logic                  matched;
      logic                  passed;
      logic [DIST_W-1:0]     latest_cm;
      logic [DIST_W-1:0]     filtered_cm;
      logic [TYPE_W-1:0]     type_out;
      logic [ERR_W-1:0]      errors;
      logic [MEAN_INT_W-1:0] mean_cm;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/core/romf_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// romf_if: channel interfaces of the range outlier mean filter
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface romf_req_if;
   logic                          valid;
   logic                          ready;
   logic [romf_pkg::ORIENT_W-1:0] orientation;
   logic [romf_pkg::DIST_W-1:0]   range_cm;
   logic [romf_pkg::TYPE_W-1:0]   sensor_code;

   modport source (output valid, orientation, range_cm, sensor_code, input ready);
   modport sink   (input valid, orientation, range_cm, sensor_code, output ready);
endinterface

interface romf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            matched;
   logic                            passed;
   logic [romf_pkg::DIST_W-1:0]     latest_cm;
   logic [romf_pkg::DIST_W-1:0]     filtered_cm;
   logic [romf_pkg::TYPE_W-1:0]     type_out;
   logic [romf_pkg::ERR_W-1:0]      errors;
   logic [romf_pkg::MEAN_INT_W-1:0] mean_cm;

   modport source (output valid, matched, passed, latest_cm, filtered_cm, type_out,
                   errors, mean_cm, input ready);
   modport sink   (input valid, matched, passed, latest_cm, filtered_cm, type_out,
                   errors, mean_cm, output ready);
endinterface

interface romf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [romf_pkg::CSR_IDX_W-1:0]  index;
   logic [romf_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/core/romf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// romf_front: request intake and classification
// Sorts each request into skip, out-of-range, direct pass or filter work.
// ----------------------------------------------------------------------------
module romf_front (
   input  romf_pkg::cfg_type   cfg,
   romf_req_if.sink            req_chan,
   input  logic                q_full,
   output logic                push,
   output romf_pkg::entry_type entry
);

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   always_comb begin
      entry.range_cm = req_chan.range_cm;
      entry.stype    = req_chan.sensor_code;
      if (req_chan.orientation != cfg.orient) begin
         entry.cls = romf_pkg::CLS_SKIP;
      end else if ((req_chan.range_cm < romf_pkg::DIST_MIN) ||
                   (req_chan.range_cm > romf_pkg::DIST_MAX)) begin
         entry.cls = romf_pkg::CLS_RANGE;
      end else if (cfg.window == '0) begin
         entry.cls = romf_pkg::CLS_PASS;
      end else begin
         entry.cls = romf_pkg::CLS_FILTER;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/romf_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// romf_queue: short queue between front and back
// Two-entry FIFO of classified requests.
// ----------------------------------------------------------------------------
module romf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  romf_pkg::entry_type wr_entry,
   output logic                full,
   input  logic                pop,
   output romf_pkg::entry_type head,
   output logic                empty
);

   romf_pkg::entry_type              slot_ff [romf_pkg::QUEUE_DEPTH];
   logic [romf_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [romf_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [romf_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full  = (count_ff == romf_pkg::QCNT_W'(romf_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/romf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// romf_back: filter sequencer and result register
// Runs deviation test, serial gain divide and mean update, then posts result.
// ----------------------------------------------------------------------------
module romf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  romf_pkg::cfg_type    cfg,
   input  logic                 q_empty,
   input  romf_pkg::entry_type  head,
   output logic                 pop,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output romf_pkg::result_type rsp_data
);

   localparam int MW   = romf_pkg::MEAN_W;
   localparam int SW   = MW + 1;
   localparam int LW   = MW + 8;
   localparam int RW   = SW + romf_pkg::WIN_W;
   localparam int NW   = SW + romf_pkg::GAIN_W;
   localparam int DW   = MW + 4;
   localparam int SHW  = DW + romf_pkg::DIV_STEPS - 1;
   localparam int KW   = romf_pkg::GAIN_W + 1;
   localparam int QW   = romf_pkg::DIV_STEPS;
   localparam int PW   = SW + QW;

   romf_pkg::back_state_type state_ff, state_in;

   // architectural state
   logic [MW-1:0]                  mean_ff, mean_in;
   logic [romf_pkg::DIST_W-1:0]    last_dist_ff, last_dist_in;
   logic [romf_pkg::DIST_W-1:0]    acc_dist_ff, acc_dist_in;
   logic [romf_pkg::TYPE_W-1:0]    last_type_ff, last_type_in;
   logic [romf_pkg::ERR_W-1:0]     errors_ff, errors_in;

   // working registers
   romf_pkg::entry_type            item_ff, item_in;
   logic [MW-1:0]                  diff_ff, diff_in;
   logic [SW-1:0]                  sum_ff, sum_in;
   logic                           xgt_ff, xgt_in;
   logic [LW-1:0]                  dev_lhs_ff, dev_lhs_in;
   logic [RW-1:0]                  dev_rhs_ff, dev_rhs_in;
   logic [NW-1:0]                  num_ff, num_in;
   logic [DW-1:0]                  den_ff, den_in;
   logic                           reject_ff, reject_in;
   logic [NW-1:0]                  rem_ff, rem_in;
   logic [SHW-1:0]                 dsh_ff, dsh_in;
   logic [QW-1:0]                  q_ff, q_in;
   logic [romf_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [KW-1:0]                  k_ff, k_in;
   logic signed [PW-1:0]           prod_ff, prod_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   romf_pkg::result_type           rsp_data_ff, rsp_data_in;

   logic                           out_free;
   logic                           commit;
   logic [MW-1:0]                  x_w;
   logic                           seed_w;
   logic                           ovf_w;
   logic                           ge_w;
   logic signed [SW-1:0]           delta_w;
   logic signed [MW+2:0]           mean_step_w;
   logic                           passed_w;
   logic                           to_mul_w;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign x_w      = {item_ff.range_cm[romf_pkg::MEAN_INT_W-1:0], romf_pkg::FRAC_W'(0)};
   assign seed_w   = (mean_ff == '0);
   assign to_mul_w = (item_ff.cls == romf_pkg::CLS_FILTER) && !seed_w;
   assign ovf_w    = {5'b0, num_ff} >= {den_ff, romf_pkg::DIV_STEPS'(0)};
   assign ge_w     = {(SHW-NW)'(0), rem_ff} >= dsh_ff;
   assign delta_w  = xgt_ff ? signed'({1'b0, diff_ff}) : -signed'({1'b0, diff_ff});
   assign mean_step_w = signed'({3'b0, mean_ff}) + signed'(prod_ff[PW-1:romf_pkg::FRAC_W]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         romf_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = romf_pkg::BK_PREP;
            end
         end
         romf_pkg::BK_PREP: begin
            state_in = to_mul_w ? romf_pkg::BK_MUL : romf_pkg::BK_FIN;
         end
         romf_pkg::BK_MUL: state_in = romf_pkg::BK_CMP;
         romf_pkg::BK_CMP: begin
            if (dev_lhs_ff > LW'(0) && ({1'b0, dev_lhs_ff} > dev_rhs_ff) && !ovf_w) begin
               state_in = romf_pkg::BK_DIV;
            end else begin
               state_in = romf_pkg::BK_UPD;
            end
         end
         romf_pkg::BK_DIV: begin
            if (cnt_ff == '0) begin
               state_in = romf_pkg::BK_GAIN;
            end
         end
         romf_pkg::BK_GAIN: state_in = romf_pkg::BK_UPD;
         romf_pkg::BK_UPD:  state_in = romf_pkg::BK_FIN;
         romf_pkg::BK_FIN: begin
            if (out_free) begin
               state_in = romf_pkg::BK_IDLE;
            end
         end
         default: state_in = romf_pkg::BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      pop    = 1'b0;
      commit = 1'b0;
      case (state_ff)
         romf_pkg::BK_IDLE: pop    = !q_empty;
         romf_pkg::BK_FIN:  commit = out_free;
         default: begin
            pop    = 1'b0;
            commit = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      item_in    = pop ? head : item_ff;
      diff_in    = diff_ff;
      sum_in     = sum_ff;
      xgt_in     = xgt_ff;
      dev_lhs_in = dev_lhs_ff;
      dev_rhs_in = dev_rhs_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      reject_in  = reject_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      q_in       = q_ff;
      cnt_in     = cnt_ff;
      k_in       = k_ff;
      prod_in    = prod_ff;

      case (state_ff)
         romf_pkg::BK_PREP: begin
            xgt_in  = x_w > mean_ff;
            diff_in = (x_w > mean_ff) ? x_w - mean_ff : mean_ff - x_w;
            sum_in  = SW'(mean_ff) + SW'(x_w);
         end
         romf_pkg::BK_MUL: begin
            dev_lhs_in = LW'(diff_ff) * LW'(romf_pkg::DEV_SCALE);
            dev_rhs_in = RW'(cfg.window) * RW'(sum_ff);
            num_in     = NW'(cfg.gain) * NW'(sum_ff);
            den_in     = DW'(diff_ff) * DW'(romf_pkg::GAIN_DIV);
         end
         romf_pkg::BK_CMP: begin
            reject_in = {1'b0, dev_lhs_ff} > dev_rhs_ff;
            rem_in    = num_ff;
            dsh_in    = {den_ff, (romf_pkg::DIV_STEPS-1)'(0)};
            q_in      = '0;
            cnt_in    = romf_pkg::CNT_W'(romf_pkg::DIV_STEPS - 1);
            if (!({1'b0, dev_lhs_ff} > dev_rhs_ff)) begin
               k_in = KW'(cfg.gain);
            end else if (ovf_w) begin
               k_in = romf_pkg::Q16_ONE;
            end
         end
         romf_pkg::BK_DIV: begin
            if (ge_w) begin
               rem_in = rem_ff - dsh_ff[NW-1:0];
            end
            q_in   = {q_ff[QW-2:0], ge_w};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
         romf_pkg::BK_GAIN: begin
            k_in = (q_ff > QW'(romf_pkg::Q16_ONE)) ? romf_pkg::Q16_ONE : q_ff[KW-1:0];
         end
         romf_pkg::BK_UPD: begin
            prod_in = PW'(delta_w) * PW'(signed'({1'b0, k_ff}));
         end
         default: begin
            item_in = pop ? head : item_ff;
         end
      endcase
   end

   // commit of one item into state and the result register
   always_comb begin
      mean_in      = mean_ff;
      last_dist_in = last_dist_ff;
      acc_dist_in  = acc_dist_ff;
      last_type_in = last_type_ff;
      errors_in    = errors_ff;
      passed_w     = 1'b0;

      case (item_ff.cls)
         romf_pkg::CLS_PASS: passed_w = 1'b1;
         romf_pkg::CLS_FILTER: passed_w = seed_w || !reject_ff;
         default: passed_w = 1'b0;
      endcase

      if (commit && (item_ff.cls != romf_pkg::CLS_SKIP)) begin
         last_dist_in = item_ff.range_cm;
         last_type_in = item_ff.stype;
         if (passed_w) begin
            acc_dist_in = item_ff.range_cm;
         end
         if (item_ff.cls == romf_pkg::CLS_FILTER) begin
            if (seed_w) begin
               mean_in = x_w;
            end else begin
               mean_in = mean_step_w[MW-1:0];
               if (reject_ff && (errors_ff != '1)) begin
                  errors_in = errors_ff + 1'b1;
               end
            end
         end
      end

      rsp_data_in = rsp_data_ff;
      if (commit) begin
         rsp_data_in.matched     = (item_ff.cls != romf_pkg::CLS_SKIP);
         rsp_data_in.passed      = passed_w;
         rsp_data_in.latest_cm   = last_dist_in;
         rsp_data_in.filtered_cm = acc_dist_in;
         rsp_data_in.type_out    = last_type_in;
         rsp_data_in.errors      = errors_in;
         rsp_data_in.mean_cm     = mean_in[MW-1:romf_pkg::FRAC_W];
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= romf_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         mean_ff      <= '0;
         last_dist_ff <= '0;
         acc_dist_ff  <= '0;
         last_type_ff <= '0;
         errors_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mean_ff      <= mean_in;
         last_dist_ff <= last_dist_in;
         acc_dist_ff  <= acc_dist_in;
         last_type_ff <= last_type_in;
         errors_ff    <= errors_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      diff_ff     <= diff_in;
      sum_ff      <= sum_in;
      xgt_ff      <= xgt_in;
      dev_lhs_ff  <= dev_lhs_in;
      dev_rhs_ff  <= dev_rhs_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      reject_ff   <= reject_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/range_outlier_mean_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// range_outlier_mean_filter: outlier-rejecting moving-average distance filter
// Latches matching distance reports, rejects implausible ones against a
// running mean and reports one result per request.
// ----------------------------------------------------------------------------
// Every request yields exactly one response, in order. A two-entry queue sits
// between the intake and the filter sequencer, and the response sits in an
// output register, so a new request is taken while a finished response still
// waits. Requests that do not match the orientation, fall outside 5..600 cm,
// arrive with the window at zero or seed the mean go from the prepare step
// straight to finish. Filtered ones add multiply, compare and update, and
// rejected ones with unsaturated gain also run the 18-step restoring divider
// for the adaptive gain k*(mean+x)/(10*|mean-x|), which sets the worst
// case. Registers are written over the csr channel (index 0 orientation,
// 1 window percent, 2 mean gain; other indexes are ignored) and should only
// change while no request is in flight.
module range_outlier_mean_filter (
   input  logic      clock,
   input  logic      reset,
   romf_req_if.sink  req_chan,
   romf_rsp_if.source rsp_chan,
   romf_csr_if.sink  csr_chan
);

   romf_pkg::cfg_type    cfg_ff, cfg_in;
   romf_pkg::entry_type  front_entry;
   romf_pkg::entry_type  q_head;
   romf_pkg::result_type rsp_data;
   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_empty;
   logic                 rsp_valid;

   // register file: always ready, decode the index and drop unknown ones
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            romf_pkg::CSR_IDX_ORIENT: cfg_in.orient = csr_chan.wdata[romf_pkg::ORIENT_W-1:0];
            romf_pkg::CSR_IDX_WINDOW: cfg_in.window = csr_chan.wdata[romf_pkg::WIN_W-1:0];
            romf_pkg::CSR_IDX_GAIN:   cfg_in.gain   = csr_chan.wdata[romf_pkg::GAIN_W-1:0];
            default:                  cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orient <= romf_pkg::ORIENT_RESET;
         cfg_ff.window <= romf_pkg::WINDOW_RESET;
         cfg_ff.gain   <= romf_pkg::GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify at intake
   romf_front u_front (
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .entry    (front_entry)
   );

   // hold classified requests until the sequencer is free
   romf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (front_entry),
      .full     (q_full),
      .pop      (pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // run the filter and post the response
   romf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .head      (q_head),
      .pop       (pop),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.matched     = rsp_data.matched;
   assign rsp_chan.passed      = rsp_data.passed;
   assign rsp_chan.latest_cm   = rsp_data.latest_cm;
   assign rsp_chan.filtered_cm = rsp_data.filtered_cm;
   assign rsp_chan.type_out    = rsp_data.type_out;
   assign rsp_chan.errors      = rsp_data.errors;
   assign rsp_chan.mean_cm     = rsp_data.mean_cm;

endmodule
`default_nettype wire

@@ rtl/core/romf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// romf_checker: port-level checks of the range outlier mean filter
// Watches the response channel and flags impossible results.
// ----------------------------------------------------------------------------
module romf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            matched,
   input logic                            passed,
   input logic [romf_pkg::DIST_W-1:0]     latest_cm,
   input logic [romf_pkg::DIST_W-1:0]     filtered_cm,
   input logic [romf_pkg::ERR_W-1:0]      errors,
   input logic [romf_pkg::MEAN_INT_W-1:0] mean_cm
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({matched, passed, latest_cm, filtered_cm, errors, mean_cm}))
      else $error("stalled response changed");

   // a passed sample is a matched one and becomes the filtered distance
   a_pass_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && passed |-> matched && (filtered_cm == latest_cm))
      else $error("passed sample not latched as filtered distance");

   // the mean never exceeds the upper end of the valid distance range
   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> mean_cm <= 10'd600)
      else $error("running mean out of range");

endmodule

bind range_outlier_mean_filter romf_checker u_romf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .matched     (rsp_chan.matched),
   .passed      (rsp_chan.passed),
   .latest_cm   (rsp_chan.latest_cm),
   .filtered_cm (rsp_chan.filtered_cm),
   .errors      (rsp_chan.errors),
   .mean_cm     (rsp_chan.mean_cm)
);
`default_nettype wire
